// File: hdl/ita_pkg.sv
package ita_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS_DEF  = 11;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // double-dabble digit correction
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } ita_state_t;

    typedef struct packed {
        logic start;
        logic shift;
    } ita_ctrl_t;

endpackage

// File: hdl/ita_dabble.sv
module ita_dabble #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
    parameter int NUM_DIGITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ita_pkg::ita_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]  mag,
    output logic                   done,
    output logic [3:0]             top_digit
);
    import ita_pkg::*;

    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int BW = NUM_DIGITS * 4;

    logic [VALUE_BITS-1:0] bin_reg;
    logic [BW-1:0]         bcd_reg;
    logic [BW-1:0]         adj;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // add-3 on every digit of 5 or more, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= BCD_ADJ_MIN)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + BCD_ADJ;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cnt_reg  <= CW'(VALUE_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bcd_reg <= {adj[BW-2:0], bin_reg[VALUE_BITS-1]};
            bin_reg <= {bin_reg[VALUE_BITS-2:0], 1'b0};
        end
        else if (ctrl.shift)
        begin
            bcd_reg <= {bcd_reg[BW-5:0], 4'h0};
        end
    end

    assign done      = done_reg;
    assign top_digit = bcd_reg[BW-1 -: 4];

endmodule

// File: hdl/integer_to_decimal_ascii_top.sv
// channel | signals                      | dir | transaction
// input   | in_valid in_stall func value | in  | one number to convert
// output  | out_valid out_stall out_char | out | one character, last on final
//         | last                         |     |
// After a number is accepted, the dabble unit runs VALUE_BITS shift-add-3 steps and then
// hands off to the emit state. That state drops each leading zero digit without sending it
// and then sends one character at a time, holding while the output is stalled.
// in_stall stays high from acceptance until the last character is loaded.
// The output register holds its character while out_stall is high.
// Reset clears the sequencer and the output valid only.
module integer_to_decimal_ascii_top #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = ita_pkg::MAX_CHARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last
);
    import ita_pkg::*;

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int RW         = $clog2(NUM_DIGITS + 1);
    localparam int NW         = $clog2(MAX_CHARS + 1);

    ita_state_t            state_reg, state_next;
    logic                  neg_reg, neg_next;
    logic                  started_reg, started_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  last_reg, last_next;

    logic [VALUE_BITS-1:0] v;
    logic                  v_neg;
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            top_digit;
    logic                  conv_done;
    logic                  accept;
    logic                  can_load;
    logic                  cap_hit;
    ita_ctrl_t             ctrl;

    assign v      = VALUE_BITS'(value);
    assign v_neg  = func & v[VALUE_BITS-1];
    assign mag    = v_neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;
    assign accept = in_valid & (state_reg == ST_IDLE);

    assign can_load = ~out_valid_reg | ~out_stall;
    assign cap_hit  = (cnt_reg == NW'(MAX_CHARS - 1));

    ita_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .mag       (mag),
        .done      (conv_done),
        .top_digit (top_digit)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        ctrl.start     = 1'b0;
        ctrl.shift     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.start   = 1'b1;
                    neg_next     = v_neg;
                    started_next = 1'b0;
                    rem_next     = RW'(NUM_DIGITS);
                    cnt_next     = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (neg_reg)
                begin
                    if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = CHAR_MINUS;
                        last_next      = cap_hit;
                        neg_next       = 1'b0;
                        cnt_next       = cnt_reg + 1'b1;
                        if (cap_hit)
                            state_next = ST_IDLE;
                    end
                end
                else if (!started_reg && top_digit == 4'h0 && rem_reg != RW'(1))
                begin
                    // leading zero: drop it without sending
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else if (can_load)
                begin
                    ctrl.shift     = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    started_next   = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + {4'h0, top_digit};
                    last_next      = (rem_reg == RW'(1)) | cap_hit;
                    if ((rem_reg == RW'(1)) || cap_hit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign in_stall  = ~accept & (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// File: hdl/ita_checker.sv
module ita_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       last
);
    import ita_pkg::*;

    // a held character must not move
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output transaction changed while stalled");

    // converter is busy right after taking a number
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before conversion");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_char == CHAR_MINUS ||
                      (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
        else $error("illegal output character");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == CHAR_MINUS |-> !last)
        else $error("sign sent as final character");

endmodule

bind integer_to_decimal_ascii_top ita_checker u_ita_checker (.*);

// File: sim/integer_to_decimal_ascii_top_tb.sv
module integer_to_decimal_ascii_top_tb;
    import ita_pkg::*;

    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;
    localparam int   TEXT_MAX      = MAX_CHARS_DEF;
    localparam int   IDLE_PCT      = 18;
    localparam int   RANDOM_NUMS   = 440;
    localparam int   QUIET_FROM    = 180;
    localparam int   QUIET_TO      = 300;

    typedef struct packed {
        logic        sgn;
        logic [31:0] raw;
    } number_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_final;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = 1'b0;
    logic [31:0] value = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic        last;

    number_t    number_q[$];
    text_char_t text_q[$];
    int         numbers_total;
    int         numbers_sent = 0;
    int         numbers_taken = 0;
    bit         in_fire = 1'b0;
    bit         failed = 1'b0;
    bit         quiet;

    integer_to_decimal_ascii_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .value    (value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_char (out_char),
        .last     (last)
    );

    always #6 clk = ~clk;

    assign quiet = (numbers_sent >= QUIET_FROM) && (numbers_sent < QUIET_TO);

    // queue the decimal text of one number, sign first, no leading zeros
    function automatic void push_text(logic sgn, logic [31:0] raw);
        logic [31:0] mag;
        logic [7:0]  digits[0:19];
        logic [7:0]  text[0:20];
        int          nd;
        int          len;
        int          count;
        text_char_t  tc;
        nd = 0;
        len = 0;
        mag = raw;
        if (sgn && raw[31])
        begin
            text[len] = CHAR_MINUS;
            len++;
            mag = ~raw + 32'd1;
        end
        if (mag == 32'd0)
        begin
            digits[0] = CHAR_ZERO;
            nd = 1;
        end
        while (mag != 32'd0)
        begin
            digits[nd] = CHAR_ZERO + 8'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end
        while (nd > 0)
        begin
            nd--;
            text[len] = digits[nd];
            len++;
        end
        count = (len > TEXT_MAX) ? TEXT_MAX : len;
        for (int k = 0; k < count; k++)
        begin
            tc.ch = text[k];
            tc.is_final = (k == count - 1);
            text_q.push_back(tc);
        end
    endfunction

    function automatic void add_number(logic sgn, logic [31:0] raw);
        number_t n;
        n.sgn = sgn;
        n.raw = raw;
        number_q.push_back(n);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin : drive_blk
        number_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (number_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = number_q.pop_front();
                in_valid <= 1'b1;
                func <= nxt.sgn;
                value <= nxt.raw;
                numbers_sent++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= rst_n && !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // monitor: sample both channels on the rising edge
    always @(posedge clk)
    begin : monitor_blk
        text_char_t exp_c;
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            push_text(func, value);
            numbers_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (text_q.size() == 0)
            begin
                $display("%0t: unexpected char 0x%02h last %0b", $time, out_char, last);
                failed = 1'b1;
            end
            else
            begin
                exp_c = text_q.pop_front();
                if (out_char !== exp_c.ch)
                begin
                    $display("%0t: out_char expected 0x%02h actual 0x%02h",
                             $time, exp_c.ch, out_char);
                    failed = 1'b1;
                end
                if (last !== exp_c.is_final)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, exp_c.is_final, last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin : stim_blk
        int          nbits;
        logic [31:0] r;
        // edge cases: zero, one, digit rollovers, extremes both ways
        add_number(FUNC_UNSIGNED, 32'd0);
        add_number(FUNC_SIGNED,   32'd0);
        add_number(FUNC_UNSIGNED, 32'd1);
        add_number(FUNC_SIGNED,   32'd1);
        add_number(FUNC_UNSIGNED, 32'd9);
        add_number(FUNC_UNSIGNED, 32'd10);
        add_number(FUNC_UNSIGNED, 32'd99);
        add_number(FUNC_SIGNED,   32'd100);
        add_number(FUNC_UNSIGNED, 32'd999999999);
        add_number(FUNC_UNSIGNED, 32'd1000000000);
        add_number(FUNC_UNSIGNED, 32'hFFFF_FFFF);
        add_number(FUNC_SIGNED,   32'hFFFF_FFFF);
        add_number(FUNC_SIGNED,   32'h8000_0000);
        add_number(FUNC_UNSIGNED, 32'h8000_0000);
        add_number(FUNC_SIGNED,   32'h8000_0001);
        add_number(FUNC_SIGNED,   32'h7FFF_FFFF);
        add_number(FUNC_UNSIGNED, 32'h7FFF_FFFF);
        add_number(FUNC_SIGNED,   32'hFFFF_FFF6);
        add_number(FUNC_SIGNED,   32'hC465_3600);
        add_number(FUNC_UNSIGNED, 32'hAAAA_AAAA);
        add_number(FUNC_SIGNED,   32'h5555_5555);
        // random magnitudes so every text length shows up
        for (int i = 0; i < RANDOM_NUMS; i++)
        begin
            nbits = $urandom_range(32, 0);
            r = $urandom();
            if (nbits < 32 && $urandom_range(3) != 0)
                r = r & ((32'd1 << nbits) - 32'd1);
            if ($urandom_range(3) == 0)
                r = ~r;
            add_number(1'($urandom_range(1)), r);
        end
        numbers_total = number_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (numbers_taken < numbers_total || text_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (!failed)
            $display("[integer_to_decimal_ascii_top] OK");
        else
            $display("[integer_to_decimal_ascii_top] ERROR");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("[integer_to_decimal_ascii_top] ERROR");
        $finish;
    end

endmodule
